// File: sv/rsle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsle_pkg
// shared types and constants of the ring symbol line encoder
// ----------------------------------------------------------------------------
package rsle_pkg;

   typedef logic [1:0] sym_type;

   localparam sym_type SYM_EMPTY = 2'd0;
   localparam sym_type SYM_POINT = 2'd1;
   localparam sym_type SYM_MARK  = 2'd2;

   localparam logic [7:0] MASK_RESET = 8'h96;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_PASS1,
      OP_PASS2,
      OP_PASS3,
      OP_FORCE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   scan_en;
   } cmd_type;

endpackage

// File: sv/ring_symbol_line_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_symbol_line_encoder
// whitens codeword bytes into a ring of symbols, rewrites it and emits it
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// req       in         start && !busy         req_data_byte
// rsp       out        rsp_valid (strobe)     rsp_symbol, rsp_last_symbol
// csr       in         csr_valid && csr_ready csr_whitening_mask
//
// a non-final byte is taken and busy stays low
// the final byte starts three scans of the ring, one symbol a cycle, a tail
// fix step and emission of one symbol a cycle, with busy high throughout
// synchronous reset clears the sequencer and sets the mask to 0x96
// results are strobed once and cannot be stalled
// ----------------------------------------------------------------------------
module ring_symbol_line_encoder import rsle_pkg::*; #(
   parameter int NUM_BYTES = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   output logic [1:0] rsp_symbol,
   output logic       rsp_last_symbol,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_whitening_mask
);

   cmd_type cmd;
   logic    hit;
   sym_type head_symbol;

   assign csr_ready  = 1'b1;
   assign rsp_symbol = head_symbol;

   rsle_ctrl #(
      .NUM_BYTES (NUM_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .hit             (hit),
      .cmd             (cmd),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_last_symbol (rsp_last_symbol)
   );

   rsle_datapath #(
      .NUM_BYTES (NUM_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .data_byte          (req_data_byte),
      .csr_valid          (csr_valid),
      .csr_whitening_mask (csr_whitening_mask),
      .hit                (hit),
      .head_symbol        (head_symbol)
   );

endmodule

// File: sv/rsle_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsle_datapath
// symbol ring, whitening mask and rewrite window at the head of the ring
// ----------------------------------------------------------------------------
module rsle_datapath import rsle_pkg::*; #(
   parameter int NUM_BYTES = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic [7:0] data_byte,
   input  logic       csr_valid,
   input  logic [7:0] csr_whitening_mask,
   output logic       hit,
   output sym_type    head_symbol
);

   localparam int SYM_COUNT = 8 * NUM_BYTES;

   logic [7:0] mask_ff;
   logic [7:0] whitened;
   sym_type    sym_ff [SYM_COUNT];
   sym_type    sym_in [SYM_COUNT];
   sym_type    win    [SYM_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_valid) begin
         mask_ff <= csr_whitening_mask;
      end
   end

   assign whitened    = data_byte ^ mask_ff;
   assign head_symbol = sym_ff[0];

   always_comb begin
      unique case (cmd.op) inside
         OP_PASS1: hit = (sym_ff[0] == SYM_POINT) && (sym_ff[1] == SYM_POINT);
         OP_PASS2: hit = (sym_ff[0] == SYM_MARK) && (sym_ff[1] == SYM_MARK) &&
                         (sym_ff[2] == SYM_MARK) && (sym_ff[3] == SYM_MARK);
         OP_PASS3: hit = (sym_ff[0] == SYM_EMPTY) && (sym_ff[1] == SYM_EMPTY) &&
                         (sym_ff[2] == SYM_EMPTY) && (sym_ff[3] == SYM_EMPTY) &&
                         (sym_ff[4] == SYM_EMPTY);
         default:  hit = 1'b0;
      endcase
   end

   always_comb begin
      win = sym_ff;
      if (cmd.scan_en && hit) begin
         unique case (cmd.op) inside
            OP_PASS1: begin
               win[0] = SYM_MARK;
               win[1] = SYM_MARK;
            end
            OP_PASS2: begin
               win[1] = SYM_POINT;
            end
            OP_PASS3: begin
               win[1] = SYM_POINT;
               win[2] = SYM_POINT;
               win[3] = SYM_POINT;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sym_in = sym_ff;
      unique case (cmd.op) inside
         OP_LOAD: begin
            for (int k = 0; k < SYM_COUNT - 8; k++) begin
               sym_in[k] = sym_ff[k + 8];
            end
            for (int j = 0; j < 8; j++) begin
               sym_in[SYM_COUNT - 8 + j] = {1'b0, whitened[j]};
            end
         end
         OP_PASS1, OP_PASS2, OP_PASS3, OP_EMIT: begin
            // rotate the ring one place toward the head
            for (int k = 0; k < SYM_COUNT - 1; k++) begin
               sym_in[k] = win[k + 1];
            end
            sym_in[SYM_COUNT - 1] = win[0];
         end
         OP_FORCE: begin
            sym_in[SYM_COUNT - 4] = SYM_MARK;
            sym_in[SYM_COUNT - 3] = SYM_POINT;
            sym_in[SYM_COUNT - 2] = SYM_POINT;
            sym_in[SYM_COUNT - 1] = SYM_EMPTY;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
   end

endmodule

// File: sv/rsle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsle_ctrl
// sequencer for byte loading, the three ring scans, tail forcing and emission
// ----------------------------------------------------------------------------
module rsle_ctrl import rsle_pkg::*; #(
   parameter int NUM_BYTES = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    hit,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid,
   output logic    rsp_last_symbol
);

   localparam int SYM_COUNT = 8 * NUM_BYTES;
   localparam int PW        = $clog2(SYM_COUNT);
   localparam int BW        = $clog2(NUM_BYTES + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PASS1 = 6'b000010,
      ST_PASS2 = 6'b000100,
      ST_PASS3 = 6'b001000,
      ST_FORCE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [BW-1:0] bytes_ff, bytes_in;
   logic [2:0]    skip_ff, skip_in;
   logic          pos_end;
   logic          last_byte;

   assign pos_end   = (pos_ff == PW'(SYM_COUNT - 1));
   assign last_byte = (bytes_ff == BW'(NUM_BYTES - 1));

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      bytes_in    = bytes_ff;
      skip_in     = (skip_ff != 3'd0) ? skip_ff - 3'd1 : 3'd0;
      cmd.op      = OP_HOLD;
      cmd.scan_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            skip_in = 3'd0;
            if (start) begin
               cmd.op = OP_LOAD;
               pos_in = '0;
               if (last_byte) begin
                  bytes_in = '0;
                  state_in = ST_PASS1;
               end else begin
                  bytes_in = bytes_ff + BW'(1);
               end
            end
         end
         ST_PASS1: begin
            cmd.op      = OP_PASS1;
            cmd.scan_en = (pos_ff <= PW'(SYM_COUNT - 2));
            pos_in      = pos_ff + PW'(1);
            if (pos_end) begin
               pos_in   = '0;
               state_in = ST_PASS2;
            end
         end
         ST_PASS2: begin
            cmd.op      = OP_PASS2;
            cmd.scan_en = (pos_ff <= PW'(SYM_COUNT - 2)) && (skip_ff == 3'd0);
            pos_in      = pos_ff + PW'(1);
            if (cmd.scan_en && hit) begin
               skip_in = 3'd3;
            end
            if (pos_end) begin
               pos_in   = '0;
               skip_in  = 3'd0;
               state_in = ST_PASS3;
            end
         end
         ST_PASS3: begin
            cmd.op      = OP_PASS3;
            cmd.scan_en = (pos_ff <= PW'(SYM_COUNT - 5)) && (skip_ff == 3'd0);
            pos_in      = pos_ff + PW'(1);
            if (cmd.scan_en && hit) begin
               skip_in = 3'd4;
            end
            if (pos_end) begin
               pos_in   = '0;
               skip_in  = 3'd0;
               state_in = ST_FORCE;
            end
         end
         ST_FORCE: begin
            cmd.op   = OP_FORCE;
            pos_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.op = OP_EMIT;
            pos_in = pos_ff + PW'(1);
            if (pos_end) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         bytes_ff <= '0;
         skip_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         bytes_ff <= bytes_in;
         skip_ff  <= skip_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_last_symbol = (state_ff == ST_EMIT) && pos_end;

endmodule
